// ----- rtl/cnc_pkg.sv -----
`timescale 1ns / 1ps

package cnc_pkg;

  localparam int MAX_MB_WIDTH    = 256;
  localparam int ENTRIES_PER_COL = 24;
  localparam int STORE_DEPTH     = MAX_MB_WIDTH * ENTRIES_PER_COL;
  localparam int COL_W           = (MAX_MB_WIDTH > 1) ? $clog2(MAX_MB_WIDTH) : 1;
  localparam int ADDR_W          = $clog2(STORE_DEPTH);
  localparam int POS_W           = 5;
  localparam int COUNT_W         = 5;
  localparam int NC_W            = 6;
  localparam int FLAGS_W         = 6;

  localparam logic [POS_W-1:0]   CB_BASE     = 5'd16;
  localparam logic [POS_W-1:0]   CR_BASE     = 5'd20;
  localparam logic [POS_W-1:0]   LAST_POS    = 5'd23;
  localparam logic [POS_W-1:0]   DC_LEFT_POS = 5'd5;
  localparam logic [POS_W-1:0]   DC_UP_POS   = 5'd10;
  localparam logic [COUNT_W-1:0] PCM_COUNT   = 5'd16;
  localparam logic [NC_W-1:0]    NC_CHROMA_DC = 6'h3F;

  // pattern flag bit positions
  localparam int FLAG_CDC = 4;
  localparam int FLAG_CAC = 5;

  typedef enum logic [2:0] {
    OP_LUMA_DC = 3'd0,
    OP_LUMA_AC = 3'd1,
    OP_CB_AC   = 3'd2,
    OP_CR_AC   = 3'd3,
    OP_CB_DC   = 3'd4,
    OP_CR_DC   = 3'd5,
    OP_PCM     = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_CAPB,
    S_PCM,
    S_FIN
  } state_e;

  // neighbor lookup for one block
  typedef struct packed {
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] addr_w;
    logic [ADDR_W-1:0] col_base;
    logic              has_a;
    logic              has_b;
  } nbr_t;

  typedef logic [15:0][3:0]        blk_map_t;
  typedef logic [255:0][COL_W-1:0] col_tab_t;

  // coding order to raster order, its own inverse
  localparam blk_map_t BLK_MAP = {4'd15, 4'd14, 4'd11, 4'd10, 4'd13, 4'd12, 4'd9, 4'd8,
                                  4'd7, 4'd6, 4'd3, 4'd2, 4'd5, 4'd4, 4'd1, 4'd0};

  // column of every 8-bit mb_x, wrapped at the line width
  function automatic col_tab_t build_col_tab();
    col_tab_t t;
    int       c;
    c = 0;
    for (int x = 0; x < 256; x++) begin
      t[x] = COL_W'(c);
      c = (c == MAX_MB_WIDTH - 1) ? 0 : c + 1;
    end
    return t;
  endfunction

  localparam col_tab_t COL_TAB = build_col_tab();

endpackage

// ----- rtl/cnc_if.sv -----
`timescale 1ns / 1ps

interface cnc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] mb_x;
  logic [7:0] mb_y;
  logic [3:0] block_index;
  logic [4:0] total_coeff;
  logic       first_in_mb;

  modport source (output valid, op, mb_x, mb_y, block_index, total_coeff, first_in_mb,
                  input ready);
  modport sink (input valid, op, mb_x, mb_y, block_index, total_coeff, first_in_mb,
                output ready);
endinterface

interface cnc_out_if;
  logic              valid;
  logic              ready;
  logic signed [5:0] nc;
  logic        [3:0] cbp_luma;
  logic              cbp_chroma_dc;
  logic              cbp_chroma_ac;

  modport source (output valid, nc, cbp_luma, cbp_chroma_dc, cbp_chroma_ac, input ready);
  modport sink (input valid, nc, cbp_luma, cbp_chroma_dc, cbp_chroma_ac, output ready);
endinterface

// ----- rtl/cnc_ram.sv -----
`timescale 1ns / 1ps

module cnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/cnc_nbr.sv -----
`timescale 1ns / 1ps

module cnc_nbr import cnc_pkg::*; (
  input  logic [2:0] op_i,
  input  logic [7:0] mb_x_i,
  input  logic [7:0] mb_y_i,
  input  logic [3:0] block_index_i,
  output nbr_t       nbr_o
);

  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  lcol;
  logic [ADDR_W-1:0] cur_base;
  logic [ADDR_W-1:0] left_base;
  logic              left_ok;
  logic              up_ok;
  logic [3:0]        r;
  logic [1:0]        c;
  logic [POS_W-1:0]  chroma_base;
  logic [POS_W-1:0]  pos_a;
  logic [POS_W-1:0]  pos_b;
  logic [POS_W-1:0]  pos_w;
  logic              a_left;
  logic              b_top;

  assign col      = COL_TAB[mb_x_i];
  assign lcol     = (col == '0) ? COL_W'(MAX_MB_WIDTH - 1) : col - 1'b1;
  // column times 24 as two shifts
  assign cur_base  = (ADDR_W'(col) << 4) + (ADDR_W'(col) << 3);
  assign left_base = (ADDR_W'(lcol) << 4) + (ADDR_W'(lcol) << 3);
  assign left_ok  = (mb_x_i != 8'd0);
  assign up_ok    = (mb_y_i != 8'd0);

  assign r = BLK_MAP[block_index_i];
  assign c = block_index_i[1:0];
  assign chroma_base = (op_e'(op_i) == OP_CR_AC) ? CR_BASE : CB_BASE;

  always_comb begin
    a_left = 1'b1;
    b_top  = 1'b1;
    pos_a  = DC_LEFT_POS;
    pos_b  = DC_UP_POS;
    pos_w  = {1'b0, block_index_i};
    unique case (op_e'(op_i))
      OP_LUMA_AC: begin
        a_left = (r[1:0] == 2'd0);
        b_top  = (r[3:2] == 2'd0);
        pos_a  = {1'b0, a_left ? BLK_MAP[4'(r + 4'd3)] : BLK_MAP[4'(r - 4'd1)]};
        pos_b  = {1'b0, b_top ? BLK_MAP[4'(r + 4'd12)] : BLK_MAP[4'(r - 4'd4)]};
      end
      OP_CB_AC, OP_CR_AC: begin
        a_left = ~c[0];
        b_top  = ~c[1];
        pos_a  = chroma_base + POS_W'({c[1], ~c[0]});
        pos_b  = chroma_base + POS_W'({~c[1], c[0]});
        pos_w  = chroma_base + POS_W'(c);
      end
      default: begin
        a_left = 1'b1;
        b_top  = 1'b1;
      end
    endcase
  end

  always_comb begin
    nbr_o.col_base = cur_base;
    nbr_o.addr_a   = (a_left ? left_base : cur_base) + ADDR_W'(pos_a);
    nbr_o.addr_b   = cur_base + ADDR_W'(pos_b);
    nbr_o.addr_w   = cur_base + ADDR_W'(pos_w);
    nbr_o.has_a    = a_left ? left_ok : 1'b1;
    nbr_o.has_b    = b_top ? up_ok : 1'b1;
  end

endmodule

// ----- rtl/cavlc_nc_context_predictor.sv -----
`timescale 1ns / 1ps

// a block steps through S_RDA, S_RDB, S_CAPB and S_FIN (I_PCM: the S_PCM sweep, then S_FIN)
// a new block is taken only once the last has left S_FIN, which holds on a stalled output;
//   the count store has a single read port (two neighbor reads, then one write-back)
// a finished result waits in the output register while the next block is taken
// reset clears the sequencer, output valid and the pattern flags; the count store
//   is not cleared and holds nothing meaningful until written

module cavlc_nc_context_predictor import cnc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  cnc_in_if.sink    in_i,
  cnc_out_if.source out_o
);

  state_e               state_q, state_d;
  nbr_t                 nbr;
  nbr_t                 nbr_q;
  op_e                  op_q;
  logic [COUNT_W-1:0]   tc_q;
  logic                 first_q;
  logic [COUNT_W-1:0]   a_q, b_q;
  logic [POS_W-1:0]     cnt_q, cnt_d;
  logic [FLAGS_W-1:0]   flags_q, flags_d;
  logic signed [NC_W-1:0] nc_q, nc_d;
  logic                 out_valid_q;
  logic                 accept;
  logic                 push;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [COUNT_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [COUNT_W-1:0]   ram_rdata;
  logic [COUNT_W:0]     sum;
  logic [COUNT_W-1:0]   pred;
  logic [FLAGS_W-1:0]   flags_base;
  logic [ADDR_W-1:0]    blk_off;

  cnc_nbr u_nbr (
    .op_i          (in_i.op),
    .mb_x_i        (in_i.mb_x),
    .mb_y_i        (in_i.mb_y),
    .block_index_i (in_i.block_index),
    .nbr_o         (nbr)
  );

  cnc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign push       = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (op_e'(in_i.op) == OP_PCM) ? S_PCM : S_RDA;
        end
      end
      S_RDA:  state_d = S_RDB;
      S_RDB:  state_d = S_CAPB;
      S_CAPB: state_d = S_FIN;
      S_PCM: begin
        if (cnt_q == LAST_POS) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (push) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // store accesses
  always_comb begin
    ram_raddr = nbr_q.addr_a;
    ram_we    = 1'b0;
    ram_waddr = nbr_q.addr_w;
    ram_wdata = tc_q;
    cnt_d     = cnt_q;
    unique case (state_q)
      S_RDB: ram_raddr = nbr_q.addr_b;
      S_PCM: begin
        ram_we    = 1'b1;
        ram_waddr = nbr_q.col_base + ADDR_W'(cnt_q);
        ram_wdata = PCM_COUNT;
        cnt_d     = cnt_q + 1'b1;
      end
      S_FIN: begin
        ram_we = push && (op_q == OP_LUMA_AC || op_q == OP_CB_AC || op_q == OP_CR_AC);
      end
      default: ram_raddr = nbr_q.addr_a;
    endcase
    if (accept) begin
      cnt_d = '0;
    end
  end

  // prediction and pattern flags
  assign sum = {1'b0, a_q} + {1'b0, b_q} + 1'b1;

  always_comb begin
    priority if (nbr_q.has_a && nbr_q.has_b) begin
      pred = sum[COUNT_W:1];
    end else if (nbr_q.has_a) begin
      pred = a_q;
    end else if (nbr_q.has_b) begin
      pred = b_q;
    end else begin
      pred = '0;
    end
  end

  assign flags_base = first_q ? '0 : flags_q;
  // luma block index within its column
  assign blk_off    = nbr_q.addr_w - nbr_q.col_base;

  always_comb begin
    nc_d    = '0;
    flags_d = flags_base;
    unique case (op_q)
      OP_LUMA_DC: nc_d = NC_W'(pred);
      OP_LUMA_AC: begin
        nc_d = NC_W'(pred);
        if (tc_q != '0) begin
          flags_d[{1'b0, blk_off[3:2]}] = 1'b1;
        end
      end
      OP_CB_AC, OP_CR_AC: begin
        nc_d = NC_W'(pred);
        if (tc_q != '0) begin
          flags_d[FLAG_CAC] = 1'b1;
        end
      end
      OP_CB_DC, OP_CR_DC: begin
        nc_d = NC_CHROMA_DC;
        if (tc_q != '0) begin
          flags_d[FLAG_CDC] = 1'b1;
        end
      end
      default: nc_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (push) begin
        flags_q     <= flags_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      nbr_q   <= nbr;
      op_q    <= op_e'(in_i.op);
      tc_q    <= in_i.total_coeff;
      first_q <= in_i.first_in_mb;
    end
    if (state_q == S_RDB) begin
      a_q <= ram_rdata;
    end
    if (state_q == S_CAPB) begin
      b_q <= ram_rdata;
    end
    if (push) begin
      nc_q <= nc_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.nc            = nc_q;
  assign out_o.cbp_luma      = flags_q[3:0];
  assign out_o.cbp_chroma_dc = flags_q[FLAG_CDC];
  assign out_o.cbp_chroma_ac = flags_q[FLAG_CAC];

  // the store is written only by the I_PCM sweep or at the end of a block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_PCM || state_q == S_FIN))
    else $error("count store written outside a write state");

  // a new result appears only when a block finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result raised without a finished block");

  // the I_PCM sweep covers exactly 24 entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PCM && cnt_q == LAST_POS) |=> (state_q == S_FIN))
    else $error("I_PCM sweep did not end after its last entry");

  // an accepted transaction always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RDA || state_q == S_PCM))
    else $error("accepted transaction not started");

  // a finished result that cannot leave holds the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_valid_q && !out_o.ready) |=> (state_q == S_FIN && out_valid_q))
    else $error("result lost while output stalled");

endmodule
